/* hw/rtl/mss_pkg.sv */
// ----------------------------------------------------------------------------
// Median of sample set: shared definitions
// Sizes of the sample store and the widths derived from them.
// ----------------------------------------------------------------------------
`default_nettype none

package mss_pkg;

	localparam int DEPTH       = 16;
	localparam int SAMPLE_BITS = 24;
	localparam int MEDIAN_BITS = SAMPLE_BITS + 1;
	localparam int CNT_BITS    = $clog2(DEPTH + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [MEDIAN_BITS-1:0] median_t;
	typedef logic [CNT_BITS-1:0]           count_t;

endpackage

`default_nettype wire

/* hw/rtl/mss_if.sv */
// ----------------------------------------------------------------------------
// Median of sample set: channel interfaces
// Valid/ready channels for samples and for median results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mss_sample_if
	import mss_pkg::*;
	;
	logic    valid;
	logic    ready;
	sample_t sample;
	logic    last;

	modport source (output valid, output sample, output last, input ready);
	modport sink (input valid, input sample, input last, output ready);
endinterface

interface mss_result_if
	import mss_pkg::*;
	;
	logic    valid;
	logic    ready;
	median_t median_doubled;
	logic    dropped;
	count_t  set_size;

	modport source (output valid, output median_doubled, output dropped, output set_size,
		input ready);
	modport sink (input valid, input median_doubled, input dropped, input set_size,
		output ready);
endinterface

`default_nettype wire

/* hw/rtl/mss_front.sv */
// ----------------------------------------------------------------------------
// Median of sample set: front queue
// Accepts samples and holds them in a short queue for the sorting back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mss_front
	import mss_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	mss_sample_if.sink   samples,
	mss_sample_if.source queued
);

	sample_t               data_q [QUEUE_DEPTH];
	logic                  last_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]  wr_q;
	logic [QPTR_BITS-1:0]  rd_q;
	logic [QCNT_BITS-1:0]  cnt_q;
	logic                  push;
	logic                  pop;

	assign samples.ready = (cnt_q != QCNT_BITS'(QUEUE_DEPTH));
	assign push          = samples.valid && samples.ready;
	assign queued.valid  = (cnt_q != '0);
	assign queued.sample = data_q[rd_q];
	assign queued.last   = last_q[rd_q];
	assign pop           = queued.valid && queued.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_q] <= samples.sample;
			last_q[wr_q] <= samples.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_BITS'(QUEUE_DEPTH))
		else $error("queue count beyond its depth");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == QCNT_BITS'(QUEUE_DEPTH)) |-> !push)
		else $error("transfer accepted into a full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> !pop)
		else $error("transfer taken from an empty queue");
`endif

endmodule

`default_nettype wire

/* hw/rtl/mss_back.sv */
// ----------------------------------------------------------------------------
// Median of sample set: sorting back end
// Inserts each sample, while the row has room, into an ordered row of cells
// and, at the end of a set, shifts the row down to the middle and forms twice the median.
// ----------------------------------------------------------------------------
`default_nettype none

module mss_back
	import mss_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	mss_sample_if.sink   queued,
	mss_result_if.source results
);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SHIFT,
		ST_SUM
	} state_t;

	state_t  state_q;
	sample_t store_q [DEPTH];
	count_t  fill_q;
	logic    ovf_q;
	count_t  shift_q;
	logic    odd_q;
	logic    drop_q;
	count_t  size_q;
	logic    out_valid_q;
	median_t out_median_q;
	logic    out_dropped_q;
	count_t  out_size_q;

	logic             pop;
	logic             room;
	count_t           fill_nx;
	count_t           shift_init;
	logic [DEPTH-1:0] gt;
	sample_t          ins_val [DEPTH];
	logic             out_free;
	median_t          sum;

	assign queued.ready = (state_q == ST_LOAD);
	assign pop          = queued.valid && queued.ready;
	assign room         = (fill_q < CNT_BITS'(DEPTH));
	assign fill_nx      = room ? fill_q + 1'b1 : fill_q;
	assign shift_init   = (fill_nx >> 1) - (fill_nx[0] ? count_t'(0) : count_t'(1));
	assign out_free     = !out_valid_q || results.ready;
	assign sum          = odd_q ? {store_q[0], 1'b0}
	                            : {store_q[0][SAMPLE_BITS-1], store_q[0]}
	                            + {store_q[1][SAMPLE_BITS-1], store_q[1]};

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			gt[i] = (CNT_BITS'(i) < fill_q) ? (store_q[i] > queued.sample) : 1'b1;
		end
		ins_val[0] = queued.sample;
		for (int i = 1; i < DEPTH; i++) begin
			ins_val[i] = gt[i-1] ? store_q[i-1] : queued.sample;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && room) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (CNT_BITS'(i) <= fill_q && gt[i]) begin
					store_q[i] <= ins_val[i];
				end
			end
		end else if (state_q == ST_SHIFT) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				store_q[i] <= store_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_LOAD;
			fill_q        <= '0;
			ovf_q         <= 1'b0;
			shift_q       <= '0;
			odd_q         <= 1'b0;
			drop_q        <= 1'b0;
			size_q        <= '0;
			out_valid_q   <= 1'b0;
			out_median_q  <= '0;
			out_dropped_q <= 1'b0;
			out_size_q    <= '0;
		end else begin
			if (out_valid_q && results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (pop) begin
						if (room) begin
							fill_q <= fill_nx;
						end else begin
							ovf_q <= 1'b1;
						end
						if (queued.last) begin
							size_q  <= fill_nx;
							odd_q   <= fill_nx[0];
							drop_q  <= ovf_q || !room;
							shift_q <= shift_init;
							state_q <= (shift_init == '0) ? ST_SUM : ST_SHIFT;
						end
					end
				end
				ST_SHIFT: begin
					shift_q <= shift_q - 1'b1;
					if (shift_q == count_t'(1)) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_median_q  <= sum;
						out_dropped_q <= drop_q;
						out_size_q    <= size_q;
						fill_q        <= '0;
						ovf_q         <= 1'b0;
						state_q       <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign results.valid          = out_valid_q;
	assign results.median_doubled = out_median_q;
	assign results.dropped        = out_dropped_q;
	assign results.set_size       = out_size_q;

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_BITS'(DEPTH))
		else $error("fill count beyond store depth");
	a_shift_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> (shift_q != '0))
		else $error("shift phase entered with nothing to shift");
	a_size_range: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (out_size_q != '0 && out_size_q <= CNT_BITS'(DEPTH)))
		else $error("result set size out of range");
`endif

endmodule

`default_nettype wire

/* hw/rtl/median_of_sample_set.sv */
// ----------------------------------------------------------------------------
// Median of sample set: top level
// Sorted-insertion median over sets of signed fixed-point samples.
// ----------------------------------------------------------------------------
// Samples arrive on the samples channel, one per transfer, and the final
// sample of a set carries last. One result per set leaves on the results
// channel: twice the median, a flag for samples discarded once the store
// held DEPTH of them, and the number of samples kept.
// A two-entry queue decouples the input from the sorting row, so samples
// that are not last stream at one transfer per cycle while the row is
// loading. With n samples kept, a last sample holds the sorting row while
// the row is shifted down by (n - 1) / 2 entries, rounded down, to its
// middle entries, and then while they are added into the result register.
// The result register frees the row once written, so the next set loads
// while a result waits; a receiver that stalls longer holds the adder and,
// once the queue is full, the samples channel. Reset empties the queue,
// clears the fill count and the discard flag, and drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module median_of_sample_set
	import mss_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	mss_sample_if.sink   samples,
	mss_result_if.source results
);

	mss_sample_if queued ();

	mss_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.queued  (queued.source)
	);

	mss_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.queued  (queued.sink),
		.results (results)
	);

endmodule

`default_nettype wire
